FILE: rtl/core/srcdr_pkg.sv
// Shared types, operation codes and score helpers for the search result cache.
package srcdr_pkg;

    // Operation codes carried on s_axis_tuser
    localparam logic [1:0] OP_PROBE = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Payload widths
    localparam int KEY_W   = 64;
    localparam int SCORE_W = 32;
    localparam int DEPTH_W = 6;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 9;
    localparam int PLY_W   = 7;

    // Mate threshold 90000.0 in Q23.8
    localparam logic signed [SCORE_W-1:0] MATE_RAW     = 32'sd23040000;
    localparam logic signed [SCORE_W-1:0] NEG_MATE_RAW = -32'sd23040000;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN    = 32'sh8000_0000;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
        logic [MOVE_W-1:0]         move;
    } entry_t;

    // Moves a mate-range score away from (away=1) or toward (away=0) zero
    // by ply whole units, saturating to the 32-bit range.
    function automatic logic signed [SCORE_W-1:0] mate_adjust(
        input logic signed [SCORE_W-1:0] score,
        input logic [PLY_W-1:0]          ply,
        input logic                      away
    );
        logic signed [SCORE_W:0]   delta;
        logic signed [SCORE_W:0]   sum;
        logic                      is_hi;
        logic                      is_lo;
        logic signed [SCORE_W-1:0] result;
        delta = $signed({18'b0, ply, 8'b0});
        is_hi = (score >= MATE_RAW);
        is_lo = (score <= NEG_MATE_RAW);
        sum   = {score[SCORE_W-1], score};
        if ((is_hi && away) || (is_lo && !away))
            sum = sum + delta;
        else if (is_hi || is_lo)
            sum = sum - delta;
        if (sum[SCORE_W] != sum[SCORE_W-1])
            result = sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        else
            result = sum[SCORE_W-1:0];
        return result;
    endfunction

endpackage

FILE: rtl/core/search_result_cache_depth_replace.sv
// Direct-mapped search result cache with depth-preferred replacement.
//
// Probe, store and the unused code each read the entry picked by the low
// INDEX_BITS of the hash from the single-port table in the accept cycle,
// then compare, adjust and write it back in ST_LOOKUP once the output
// register is free; no new transaction is accepted before that. Clear
// sweeps the table one entry per cycle over all 2^INDEX_BITS entries
// (65536 at the default), then returns its one result. The same sweep runs
// after reset; s_axis_tready stays low throughout it. A finished result
// waits in the output register while the next transaction is accepted.
module search_result_cache_depth_replace
    import srcdr_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    // tdata: key_hash[63:0], new_score[95:64], search_depth[101:96],
    //        bound_kind[103:102], move_index[112:104], ply_distance[119:113]
    input  logic [119:0] s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: found_score[31:0], found_depth[37:32], found_bound[39:38],
    //        found_move[48:40], zero fill[55:49]
    output logic [55:0]  m_axis_tdata,
    // tuser: hit[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready
);

    localparam int SLOTS = 1 << INDEX_BITS;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOKUP,
        ST_CLR_DONE
    } state_t;

    // Input fields
    logic [KEY_W-1:0]          in_key;
    logic signed [SCORE_W-1:0] in_score;
    logic [DEPTH_W-1:0]        in_depth;
    logic [BOUND_W-1:0]        in_bound;
    logic [MOVE_W-1:0]         in_move;
    logic [PLY_W-1:0]          in_ply;

    assign in_key   = s_axis_tdata[63:0];
    assign in_score = s_axis_tdata[95:64];
    assign in_depth = s_axis_tdata[101:96];
    assign in_bound = s_axis_tdata[103:102];
    assign in_move  = s_axis_tdata[112:104];
    assign in_ply   = s_axis_tdata[119:113];

    // Control state
    state_t                state_reg, state_next;
    logic [INDEX_BITS-1:0] sweep_idx_reg, sweep_idx_next;
    logic                  clr_pend_reg, clr_pend_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg, out_hit_next;
    logic [48:0]           out_data_reg, out_data_next;

    // Request payload
    logic [1:0]                op_reg;
    entry_t                    req_reg;
    logic [PLY_W-1:0]          ply_reg;

    // Table
    entry_t                    mem [SLOTS];
    entry_t                    rd_entry_reg;
    entry_t                    wr_entry;
    logic [INDEX_BITS-1:0]     wr_addr;
    logic                      wr_en;

    logic                      accept;
    logic                      out_free;
    logic                      key_match;
    logic                      replace;
    logic signed [SCORE_W-1:0] probe_score;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Compare against the entry read on accept
    assign key_match   = (rd_entry_reg.key == req_reg.key);
    assign replace     = !key_match || (rd_entry_reg.depth <= req_reg.depth);
    assign probe_score = mate_adjust(rd_entry_reg.score, ply_reg, 1'b0);

    // Next-state and result logic
    always_comb
    begin
        state_next     = state_reg;
        sweep_idx_next = sweep_idx_reg;
        clr_pend_next  = clr_pend_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_hit_next   = out_hit_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = req_reg.key[INDEX_BITS-1:0];
        wr_entry       = req_reg;

        unique case (state_reg)
            ST_SWEEP:
            begin
                wr_en          = 1'b1;
                wr_addr        = sweep_idx_reg;
                wr_entry       = '0;
                sweep_idx_next = sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == INDEX_BITS'(SLOTS - 1))
                    state_next = clr_pend_reg ? ST_CLR_DONE : ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == OP_CLEAR)
                    begin
                        state_next     = ST_SWEEP;
                        sweep_idx_next = '0;
                        clr_pend_next  = 1'b1;
                    end
                    else
                        state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_hit_next   = 1'b0;
                    out_data_next  = '0;
                    if (op_reg == OP_PROBE && key_match)
                    begin
                        out_hit_next  = 1'b1;
                        out_data_next = {rd_entry_reg.move, rd_entry_reg.bound,
                                         rd_entry_reg.depth, probe_score};
                    end
                    wr_en = (op_reg == OP_STORE) && replace;
                end
            end
            ST_CLR_DONE:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    clr_pend_next  = 1'b0;
                    out_valid_next = 1'b1;
                    out_hit_next   = 1'b0;
                    out_data_next  = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_idx_reg <= '0;
            clr_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_idx_reg <= sweep_idx_next;
            clr_pend_reg  <= clr_pend_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Request capture; store scores are adjusted on the way in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= s_axis_tuser;
            req_reg.key   <= in_key;
            req_reg.score <= mate_adjust(in_score, in_ply, 1'b1);
            req_reg.depth <= in_depth;
            req_reg.bound <= in_bound;
            req_reg.move  <= in_move;
            ply_reg       <= in_ply;
        end
    end

    // Table: one write per cycle; the read happens on accept and is held
    // through any output stall
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_entry;
        if (accept)
            rd_entry_reg <= mem[in_key[INDEX_BITS-1:0]];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {7'b0, out_data_reg};

endmodule

FILE: rtl/core/srcdr_checker.sv
// Port-level checks for the search result cache, bound to the top level.
module srcdr_checker
    import srcdr_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic [119:0] s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [55:0]  m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready
);

    // A result without a hit carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("miss result with nonzero fields");

    // Accepted clear starts the sweep: no transaction taken next cycle
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_CLEAR |=> !s_axis_tready)
        else $error("input accepted right after a clear");

    // Clearing pass after reset holds off input
    a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready)
        else $error("input ready during the post-reset sweep");

    // Stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind search_result_cache_depth_replace srcdr_checker u_srcdr_checker (.*);
